@@ rtl/core/lg3_pkg.sv @@
// Shared types, constants and state encodings for the 3x3 luma blur core.
// Used by lg3_cell, luma_gaussian_3x3_stream_core and lg3_chk.
`timescale 1ns / 1ps

package lg3_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int LINE_WIDTH_W     = 11;
    localparam int LINE_WIDTH_RESET = 640;
    localparam int MIN_WIDTH        = 2;

    localparam int PIXEL_W = 24;
    localparam int LUMA_W  = 8;
    localparam int SUM_W   = 12;

    localparam int LUMA_R_COEF = 77;
    localparam int LUMA_G_COEF = 150;
    localparam int LUMA_B_COEF = 29;

    typedef logic [LUMA_W-1:0] luma_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic shift_en;
        logic drop_oldest;
        logic double_row;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        RF_IDLE,
        RF_FAR,
        RF_NEAR,
        RF_LAST
    } refill_state_t;

endpackage

@@ rtl/core/lg3_ram.sv @@
// Generic simple dual-port RAM: one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module lg3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b) begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/core/lg3_cell.sv @@
// One row cell of the 3x3 window: holds two older taps of its row and adds the
// row's weighted sum to the partial sum handed in from the previous cell.
// Depends on lg3_pkg.
`timescale 1ns / 1ps

module lg3_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  lg3_pkg::cell_ctl_t ctl,
    input  lg3_pkg::luma_t    sample_in,
    input  lg3_pkg::sum_t     sum_in,
    output lg3_pkg::sum_t     sum_out
);

    lg3_pkg::luma_t hist1_reg;
    lg3_pkg::luma_t hist2_reg;
    lg3_pkg::sum_t  row_sum;
    lg3_pkg::sum_t  oldest;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist1_reg <= '0;
            hist2_reg <= '0;
        end else if (ctl.shift_en) begin
            hist1_reg <= sample_in;
            hist2_reg <= hist1_reg;
        end
    end

    always_comb begin
        oldest  = ctl.drop_oldest ? '0 : lg3_pkg::SUM_W'(hist2_reg);
        row_sum = lg3_pkg::SUM_W'(sample_in) + (lg3_pkg::SUM_W'(hist1_reg) << 1) + oldest;
        sum_out = sum_in + (ctl.double_row ? (row_sum << 1) : row_sum);
    end

endmodule

@@ rtl/core/luma_gaussian_3x3_stream_core.sv @@
// Top level of the 3x3 Gaussian luma blur core.
// Depends on lg3_pkg, lg3_ram and lg3_cell.
`timescale 1ns / 1ps

// The core takes one RGB pixel per clock and returns one blurred pixel per clock
// in steady state unless the output stalls or a refill runs; the result for a
// pixel passes the input stage and then the output register after the transfer
// of the pixel one row and one column below it. Luma samples go into a circular
// line memory with one write port and two read ports, which fetch the newest tap
// of the middle and oldest rows for every pixel; three row cells hold the older
// taps and chain the weighted sum. The line memory is not cleared after reset:
// a fill count makes samples from before the first pixel read as zero. After
// each write of the line width the input is held off in RF_FAR, RF_NEAR and
// RF_LAST while the row cells reload their taps from the line memory.

module luma_gaussian_3x3_stream_core #(
    parameter int MAX_WIDTH = lg3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lg3_pkg::LINE_WIDTH_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lg3_pkg::PIXEL_W-1:0]       s_pixel_rgb,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lg3_pkg::PIXEL_W-1:0]       m_blurred_rgb
);

    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int AW       = $clog2(2 * MAX_WIDTH + 3);
    localparam int DEPTH    = 1 << AW;
    localparam int FW       = $clog2(2 * MAX_WIDTH + 3);
    localparam int FILL_MAX = 2 * MAX_WIDTH + 2;
    localparam int SW       = $clog2(MAX_WIDTH + 3);
    localparam int RST_W    = (lg3_pkg::LINE_WIDTH_RESET > MAX_WIDTH) ?
                              MAX_WIDTH : lg3_pkg::LINE_WIDTH_RESET;

    lg3_pkg::refill_state_t rf_state_reg;
    lg3_pkg::refill_state_t rf_state_next;

    logic [WW-1:0]  weff_reg;
    logic [WW-1:0]  weff_next;
    logic [AW-1:0]  wr_ptr_reg;
    logic [FW-1:0]  fill_reg;
    logic [SW-1:0]  seen_reg;
    logic [SW-1:0]  seen_next;
    lg3_pkg::luma_t l0_reg;
    logic           ok_a_reg;
    logic           ok_b_reg;
    logic           s1_vld_reg;
    logic           s1_emit_reg;
    logic           s1_skip_reg;
    logic           m_valid_reg;
    lg3_pkg::luma_t m_data_reg;

    logic           accept;
    logic           s1_adv;
    logic           rd_en;
    logic [1:0]     rd_off;
    logic [WW:0]    dist_a;
    logic [WW+1:0]  dist_b;
    logic [AW-1:0]  raddr_a;
    logic [AW-1:0]  raddr_b;
    lg3_pkg::luma_t rdata_a;
    lg3_pkg::luma_t rdata_b;
    logic [15:0]    luma_acc;
    lg3_pkg::luma_t luma_new;
    logic           emit_next;
    logic           skip_next;
    logic           refill_shift;

    lg3_pkg::cell_ctl_t ctl_row0;
    lg3_pkg::cell_ctl_t ctl_row1;
    lg3_pkg::cell_ctl_t ctl_row2;
    lg3_pkg::luma_t     in_row1;
    lg3_pkg::luma_t     in_row2;
    lg3_pkg::sum_t      sum_row0;
    lg3_pkg::sum_t      sum_row1;
    lg3_pkg::sum_t      sum_row2;

    always_comb begin
        if (32'(cfg_wr_data) < 32'(lg3_pkg::MIN_WIDTH)) begin
            weff_next = WW'(lg3_pkg::MIN_WIDTH);
        end else if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
            weff_next = WW'(MAX_WIDTH);
        end else begin
            weff_next = WW'(cfg_wr_data);
        end
    end

    always_comb begin
        luma_acc = 16'(s_pixel_rgb[23:16]) * 16'(lg3_pkg::LUMA_R_COEF)
                 + 16'(s_pixel_rgb[15:8])  * 16'(lg3_pkg::LUMA_G_COEF)
                 + 16'(s_pixel_rgb[7:0])   * 16'(lg3_pkg::LUMA_B_COEF);
        luma_new = luma_acc[15:8];
    end

    always_comb begin
        if (32'(seen_reg) < 32'(weff_reg) + 32'd2) begin
            seen_next = seen_reg + SW'(1);
        end else begin
            seen_next = seen_reg;
        end
        emit_next = (32'(seen_next) >= 32'(weff_reg) + 32'd2);
        skip_next = (32'(seen_reg) == 32'(weff_reg) + 32'd1);
    end

    assign s1_adv  = s1_vld_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready = (rf_state_reg == lg3_pkg::RF_IDLE) && (!s1_vld_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    always_comb begin
        rf_state_next = rf_state_reg;
        rd_off        = 2'd0;
        rd_en         = accept;
        refill_shift  = 1'b0;
        case (rf_state_reg)
            lg3_pkg::RF_IDLE: begin
                rf_state_next = lg3_pkg::RF_IDLE;
            end
            lg3_pkg::RF_FAR: begin
                rd_off        = 2'd2;
                rd_en         = 1'b1;
                rf_state_next = lg3_pkg::RF_NEAR;
            end
            lg3_pkg::RF_NEAR: begin
                rd_off        = 2'd1;
                rd_en         = 1'b1;
                refill_shift  = 1'b1;
                rf_state_next = lg3_pkg::RF_LAST;
            end
            lg3_pkg::RF_LAST: begin
                refill_shift  = 1'b1;
                rf_state_next = lg3_pkg::RF_IDLE;
            end
            default: begin
                rf_state_next = lg3_pkg::RF_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            rf_state_next = lg3_pkg::RF_FAR;
        end
    end

    always_comb begin
        dist_a  = {1'b0, weff_reg} + (WW + 1)'(rd_off);
        dist_b  = {1'b0, weff_reg, 1'b0} + (WW + 2)'(rd_off);
        raddr_a = wr_ptr_reg - AW'(dist_a);
        raddr_b = wr_ptr_reg - AW'(dist_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_state_reg <= lg3_pkg::RF_IDLE;
            weff_reg     <= WW'(RST_W);
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            seen_reg     <= '0;
            s1_vld_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_skip_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            ok_a_reg     <= 1'b0;
            ok_b_reg     <= 1'b0;
        end else begin
            rf_state_reg <= rf_state_next;
            if (cfg_wr_en) begin
                weff_reg <= weff_next;
            end
            if (rd_en) begin
                ok_a_reg <= (32'(fill_reg) >= 32'(dist_a));
                ok_b_reg <= (32'(fill_reg) >= 32'(dist_b));
            end
            if (accept) begin
                wr_ptr_reg  <= wr_ptr_reg + AW'(1);
                seen_reg    <= seen_next;
                s1_vld_reg  <= 1'b1;
                s1_emit_reg <= emit_next;
                s1_skip_reg <= skip_next;
                if (32'(fill_reg) != FILL_MAX) begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end else if (s1_adv) begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_adv && s1_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            l0_reg <= luma_new;
        end
        if (s1_adv && s1_emit_reg) begin
            m_data_reg <= sum_row2[lg3_pkg::SUM_W-1:4];
        end
    end

    lg3_ram #(
        .WIDTH (lg3_pkg::LUMA_W),
        .DEPTH (DEPTH)
    ) u_line_mem (
        .aclk    (aclk),
        .we      (accept),
        .waddr   (wr_ptr_reg),
        .wdata   (luma_new),
        .re_a    (rd_en),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (rd_en),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    always_comb begin
        ctl_row0.shift_en    = s1_adv;
        ctl_row0.drop_oldest = s1_skip_reg;
        ctl_row0.double_row  = 1'b0;
        ctl_row1.shift_en    = s1_adv || refill_shift;
        ctl_row1.drop_oldest = 1'b0;
        ctl_row1.double_row  = 1'b1;
        ctl_row2.shift_en    = s1_adv || refill_shift;
        ctl_row2.drop_oldest = 1'b0;
        ctl_row2.double_row  = 1'b0;
        in_row1 = ok_a_reg ? rdata_a : '0;
        in_row2 = ok_b_reg ? rdata_b : '0;
    end

    lg3_cell u_cell_row0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_row0),
        .sample_in (l0_reg),
        .sum_in    ('0),
        .sum_out   (sum_row0)
    );

    lg3_cell u_cell_row1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_row1),
        .sample_in (in_row1),
        .sum_in    (sum_row0),
        .sum_out   (sum_row1)
    );

    lg3_cell u_cell_row2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_row2),
        .sample_in (in_row2),
        .sum_in    (sum_row1),
        .sum_out   (sum_row2)
    );

    assign m_valid       = m_valid_reg;
    assign m_blurred_rgb = {m_data_reg, m_data_reg, m_data_reg};

endmodule

@@ rtl/core/lg3_chk.sv @@
// Port-level checker for the 3x3 luma blur core, bound to its top level.
// Depends on lg3_pkg and luma_gaussian_3x3_stream_core.
`timescale 1ns / 1ps

module lg3_prop_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [lg3_pkg::PIXEL_W-1:0]      m_blurred_rgb
);

    // A result always carries the same luma in all three color bytes.
    a_gray_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_blurred_rgb[23:16] == m_blurred_rgb[15:8]) &&
                    (m_blurred_rgb[15:8] == m_blurred_rgb[7:0]))
        else $error("result bytes differ");

    // A stalled result keeps its value until the transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blurred_rgb))
        else $error("stalled result changed");

    // A width write makes the core reload its row taps before taking a pixel.
    a_cfg_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input taken right after a width write");

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind luma_gaussian_3x3_stream_core lg3_prop_chk u_lg3_prop_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_wr_en     (cfg_wr_en),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_blurred_rgb (m_blurred_rgb)
);

@@ dv/lg3_chk.sv @@
// Checker for the 3x3 luma blur core: watches the width writes and both channels,
// predicts every blurred pixel and compares it with the output transfers.
// Depends on lg3_pkg for widths, coefficients and the reset line width.
`timescale 1ns / 1ps

module lg3_chk #(
    parameter int MAX_WIDTH = lg3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lg3_pkg::LINE_WIDTH_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [lg3_pkg::PIXEL_W-1:0]       s_pixel_rgb,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [lg3_pkg::PIXEL_W-1:0]       m_blurred_rgb,
    output int                                fail_cnt,
    output int                                checked_cnt,
    output int                                pending_cnt
);

    localparam int WIN_DEPTH = 2 * MAX_WIDTH + 3;

    lg3_pkg::luma_t                    luma_win [0:WIN_DEPTH-1];
    int unsigned                       pixels_seen;
    logic [lg3_pkg::LINE_WIDTH_W-1:0]  line_width;
    logic [lg3_pkg::PIXEL_W-1:0]       blurred_q [$];

    function automatic lg3_pkg::luma_t rgb_to_luma(input logic [lg3_pkg::PIXEL_W-1:0] rgb);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        return lg3_pkg::luma_t'((r * lg3_pkg::LUMA_R_COEF + g * lg3_pkg::LUMA_G_COEF
                                 + b * lg3_pkg::LUMA_B_COEF) >> 8);
    endfunction

    // Shifts one pixel into the window and returns the blurred pixel it completes, if any.
    task automatic blur_step(input logic [lg3_pkg::PIXEL_W-1:0] rgb, output bit produced,
                             output logic [lg3_pkg::PIXEL_W-1:0] blurred);
        int unsigned    w;
        int unsigned    prior;
        int unsigned    sum;
        lg3_pkg::luma_t y;
        w = line_width;
        if (w < lg3_pkg::MIN_WIDTH) w = lg3_pkg::MIN_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        prior = pixels_seen;
        for (int k = WIN_DEPTH - 1; k > 0; k--) luma_win[k] = luma_win[k-1];
        luma_win[0] = rgb_to_luma(rgb);
        if (prior < w + 2) pixels_seen = prior + 1;
        produced = (pixels_seen >= w + 2);
        blurred  = '0;
        if (produced) begin
            sum = luma_win[2*w+2] + 2 * luma_win[2*w+1] + luma_win[2*w]
                + 2 * luma_win[w+2] + 4 * luma_win[w+1] + 2 * luma_win[w]
                + 2 * luma_win[1] + luma_win[0];
            // The first result after the count fills up leaves out the lower-left tap.
            if (prior != w + 1) sum += luma_win[2];
            y = lg3_pkg::luma_t'(sum / 16);
            blurred = {y, y, y};
        end
    endtask

    always @(posedge aclk) begin
        bit                          produced;
        logic [lg3_pkg::PIXEL_W-1:0] blurred;
        logic [lg3_pkg::PIXEL_W-1:0] want;
        if (!aresetn) begin
            foreach (luma_win[k]) luma_win[k] = '0;
            pixels_seen = 0;
            line_width  = lg3_pkg::LINE_WIDTH_W'(lg3_pkg::LINE_WIDTH_RESET);
            blurred_q.delete();
        end else begin
            if (cfg_wr_en) line_width = cfg_wr_data;
            if (s_valid && s_ready) begin
                blur_step(s_pixel_rgb, produced, blurred);
                if (produced) blurred_q.push_back(blurred);
            end
            if (m_valid && m_ready) begin
                if (blurred_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected transfer, expected none, got blurred_rgb=%06h",
                             $time, m_blurred_rgb);
                end else begin
                    want = blurred_q.pop_front();
                    checked_cnt++;
                    if (m_blurred_rgb !== want) begin
                        fail_cnt++;
                        $display("%0t: blurred_rgb mismatch, expected %06h, got %06h",
                                 $time, want, m_blurred_rgb);
                    end
                end
            end
        end
        pending_cnt <= blurred_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the 3x3 luma blur testbench: clock, reset, width writes, pixel stimulus
// and output back-pressure. Depends on lg3_pkg, lg3_chk and the core itself.
`timescale 1ns / 1ps

module tb_top;

    localparam int    HEAVY_PCT    = 66;
    localparam int    LIGHT_PCT    = 11;
    localparam int    SETTLE_CYCLES = 16;
    localparam int    MODE_RUN     = 40;
    localparam int    LONG_HOLD    = 300;
    localparam int    PIXEL_MAX    = 24'hffffff;
    localparam int    WIDTH_MAX    = 11'h7ff;
    localparam time   TIMEOUT_NS   = 5_000_000;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [lg3_pkg::LINE_WIDTH_W-1:0]  cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic [lg3_pkg::PIXEL_W-1:0]       s_pixel_rgb;
    logic                              m_valid;
    logic                              m_ready;
    logic [lg3_pkg::PIXEL_W-1:0]       m_blurred_rgb;

    int         fail_cnt;
    int         checked_cnt;
    int         pending_cnt;
    int         pixel_cnt;
    int         width_cnt;
    int         hold_req;
    flow_mode_t flow_mode;

    luma_gaussian_3x3_stream_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_rgb   (s_pixel_rgb),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blurred_rgb (m_blurred_rgb)
    );

    lg3_chk chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_rgb   (s_pixel_rgb),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blurred_rgb (m_blurred_rgb),
        .fail_cnt      (fail_cnt),
        .checked_cnt   (checked_cnt),
        .pending_cnt   (pending_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d blurred pixels still expected", $time, pending_cnt);
        $display("status: fail");
        $finish;
    end

    function automatic int src_idle_pct();
        case (flow_mode)
            FLOW_SRC_IDLE: return HEAVY_PCT;
            FLOW_BOTH:     return LIGHT_PCT;
            default:       return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (flow_mode)
            FLOW_SINK_STALL: return HEAVY_PCT;
            FLOW_BOTH:       return LIGHT_PCT;
            default:         return 0;
        endcase
    endfunction

    // Each new value of hold_req starts one long stretch with the output held off.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct());
            end
        end
    end

    function automatic logic [lg3_pkg::PIXEL_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return lg3_pkg::PIXEL_W'(PIXEL_MAX);
            default: return lg3_pkg::PIXEL_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [lg3_pkg::PIXEL_W-1:0] rgb);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct()) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_rgb <= rgb;
        do @(posedge aclk); while (!s_ready);
        pixel_cnt++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [lg3_pkg::LINE_WIDTH_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_cnt++;
    endtask

    task automatic run_width(input logic [lg3_pkg::LINE_WIDTH_W-1:0] w, input int count);
        write_width(w);
        for (int i = 0; i < count; i++) begin
            if (i % MODE_RUN == 0) flow_mode = flow_mode_t'($urandom_range(3));
            send_pixel(random_pixel());
        end
        drain_results();
    endtask

    initial begin
        logic [lg3_pkg::PIXEL_W-1:0] directed [$];
        directed = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
                     24'hffffff, 24'h000000, 24'hffffff, 24'h808080, 24'h7f7f7f,
                     24'h010101, 24'hfefefe, 24'haaaaaa, 24'h555555, 24'hff00ff,
                     24'h00ffff, 24'hffff00, 24'h123456, 24'hfedcba, 24'hffffff,
                     24'hffffff, 24'hffffff, 24'hffffff, 24'h000000};
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_pixel_rgb = '0;
        hold_req    = 0;
        pixel_cnt   = 0;
        width_cnt   = 0;
        flow_mode   = FLOW_FREE;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero width clamps to the narrowest line; the first results see the cleared window.
        write_width('0);
        foreach (directed[i]) send_pixel(directed[i]);
        drain_results();

        run_width(11'd1, 30);
        run_width(11'd3, 30);
        // Growing the width past the fill count makes the lower-left tap drop out once more.
        run_width(11'd9, 30);
        run_width(lg3_pkg::LINE_WIDTH_W'($urandom_range(20, 4)), 30);
        run_width(lg3_pkg::LINE_WIDTH_W'(WIDTH_MAX), 1032);
        run_width(11'd1024, 20);
        run_width(lg3_pkg::LINE_WIDTH_W'(lg3_pkg::LINE_WIDTH_RESET), 20);

        // Hold the output off long enough for the core to fill up and stall its input.
        write_width(11'd2);
        flow_mode = FLOW_FREE;
        hold_req++;
        for (int i = 0; i < 40; i++) send_pixel(random_pixel());
        drain_results();

        run_width(lg3_pkg::LINE_WIDTH_W'($urandom_range(30, 2)), 40);

        $display("run covered %0d pixels over %0d line width settings, clamped widths included",
                 pixel_cnt, width_cnt);
        $display("%0d blurred pixels compared, %0d mismatches", checked_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
